// ===== rtl/core/tnig_pkg.sv =====
`default_nettype none

package tnig_pkg;

  localparam int IDX_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int GRID_W  = 9;
  localparam int RAD_W   = 2;
  localparam int CFG_IDX_W = 1;

  // Largest radius; smaller codes fall back to radius two.
  localparam logic [RAD_W-1:0] RAD_LARGE = 2'd3;
  localparam logic [RAD_W-1:0] RAD_SMALL = 2'd2;

  // Slot numbers of the final neighbour for each radius.
  localparam logic [SLOT_W-1:0] LAST_SLOT_LARGE = 6'd47;
  localparam logic [SLOT_W-1:0] LAST_SLOT_SMALL = 6'd23;

  localparam logic [GRID_W-1:0] GRID_WIDTH_RESET = 9'd256;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 1'b0,
    CFG_RADIUS     = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/toroidal_neighbour_index_generator_top.sv =====
// Toroidal neighbour index generator.
// A word on the in_ stream carries a linear cell index; for it the block
// sends 24 (radius 2) or 48 (radius 3) words on the out_ stream, one per
// cell of the surrounding block with the centre left out, rows from the
// upper offset down, columns left to right, both wrapped on the torus.
// out_tlast marks the final word of each centre cell.
// Grid width and radius are set through the cfg_ write port; the user must
// write them only while the block is idle (not enforced by the block).
// Reset restores width 256 and radius 3 and empties every stage.
// The front splits the index into row and column with a shared divider
// that retires two quotient bits per cycle. A two-entry queue holds
// split cells for the back, which sends one word per cycle while the queue
// has a cell and out_tready is high, the head of the queue passing through
// the s1 and output registers. The input buffer and queue let the front
// take later words while the back is still sending; the output stream sets
// the sustained rate. When out_tready is low the back holds its word and
// the queue and input buffer fill, after which in_tready drops.
`default_nettype none

module toroidal_neighbour_index_generator_top #(
  parameter int MAX_WIDTH = 256
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [15:0]                  in_tdata,   // [15:0] cell_index
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [23:0]                  out_tdata,  // [15:0] neighbour_index, [21:16] slot
  output logic                         out_tlast,
  input  wire                          cfg_we,
  input  wire  [tnig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [tnig_pkg::GRID_W-1:0]  cfg_wdata
);
  import tnig_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW < GRID_W) ? CW : GRID_W;

  logic [GRID_W-1:0] grid_width_r;
  logic [RAD_W-1:0]  radius_r;
  logic [WW-1:0]     width_eff;
  logic [RAD_W-1:0]  rad_eff;

  logic              f_valid;
  logic              f_ready;
  logic [WW-1:0]     f_row;
  logic [WW-1:0]     f_col;
  logic              q_valid;
  logic              q_pop;
  logic [2*WW-1:0]   q_data;
  idx_t              b_index;
  slot_t             b_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_WIDTH_RESET;
      radius_r     <= RAD_LARGE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH: grid_width_r <= cfg_wdata;
        CFG_RADIUS:     radius_r     <= cfg_wdata[RAD_W-1:0];
        default:        ;
      endcase
    end
  end

  // A zero width acts as one, anything past the limit as the limit.
  always_comb begin
    if (grid_width_r == '0) begin
      width_eff = WW'(1);
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(grid_width_r);
    end
  end

  assign rad_eff = (radius_r == RAD_LARGE) ? RAD_LARGE : RAD_SMALL;

  tnig_front #(
    .WW (WW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_index  (in_tdata),
    .width     (width_eff),
    .res_valid (f_valid),
    .res_ready (f_ready),
    .res_row   (f_row),
    .res_col   (f_col)
  );

  tnig_queue #(
    .DATA_W (2 * WW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_row, f_col}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  tnig_back #(
    .WW (WW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (width_eff),
    .rad        (rad_eff),
    .head_valid (q_valid),
    .head_row   (q_data[2*WW-1:WW]),
    .head_col   (q_data[WW-1:0]),
    .head_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_index  (b_index),
    .out_slot   (b_slot),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, b_slot, b_index};

endmodule

`default_nettype wire

// ===== rtl/core/tnig_front.sv =====
`default_nettype none

module tnig_front #(
  parameter int WW = 9
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  tnig_pkg::idx_t  in_index,
  input  wire  [WW-1:0]         width,
  output logic                  res_valid,
  input  wire                   res_ready,
  output logic [WW-1:0]         res_row,
  output logic [WW-1:0]         res_col
);
  import tnig_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_COL,
    F_ROW,
    F_DONE
  } front_state_t;

  front_state_t  state_r;
  logic          buf_valid_r;
  idx_t          buf_idx_r;
  idx_t          div_r;
  logic [WW-1:0] rem_r;
  logic [2:0]    cnt_r;
  logic [WW-1:0] row_r;
  logic [WW-1:0] col_r;

  logic [WW:0]   t1;
  logic [WW:0]   t2;
  logic          q1;
  logic          q2;
  logic [WW-1:0] r1;
  logic [WW-1:0] r2;
  logic          in_take;

  // Two restoring division steps per cycle: the dividend shifts left and
  // takes the quotient bits in at the bottom.
  always_comb begin
    t1 = {rem_r, div_r[IDX_W-1]};
    q1 = (t1 >= {1'b0, width});
    r1 = q1 ? WW'(t1 - {1'b0, width}) : WW'(t1);
    t2 = {r1, div_r[IDX_W-2]};
    q2 = (t2 >= {1'b0, width});
    r2 = q2 ? WW'(t2 - {1'b0, width}) : WW'(t2);
  end

  assign in_ready  = !buf_valid_r;
  assign in_take   = in_valid && !buf_valid_r;
  assign res_valid = (state_r == F_DONE);
  assign res_row   = row_r;
  assign res_col   = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      buf_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_take) begin
        buf_valid_r <= 1'b1;
        buf_idx_r   <= in_index;
      end
      unique case (state_r)
        F_IDLE: begin
          if (buf_valid_r) begin
            buf_valid_r <= 1'b0;
            div_r       <= buf_idx_r;
            rem_r       <= '0;
            cnt_r       <= '0;
            state_r     <= F_COL;
          end
        end
        F_COL: begin
          div_r <= {div_r[IDX_W-3:0], q1, q2};
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            // Remainder is the column; the quotient is divided again.
            col_r   <= r2;
            rem_r   <= '0;
            state_r <= F_ROW;
          end else begin
            rem_r <= r2;
          end
        end
        F_ROW: begin
          div_r <= {div_r[IDX_W-3:0], q1, q2};
          rem_r <= r2;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            row_r   <= r2;
            state_r <= F_DONE;
          end
        end
        F_DONE: begin
          if (res_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_row < width) && (res_col < width))
    else $error("front result outside the grid");

  a_buf_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r && (state_r != F_IDLE) |=> buf_valid_r)
    else $error("input buffer lost a word");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_col))
    else $error("front result changed while waiting");

endmodule

`default_nettype wire

// ===== rtl/core/tnig_queue.sv =====
`default_nettype none

module tnig_queue #(
  parameter int DATA_W = 18
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  wire  [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  wire               pop,
  output logic [DATA_W-1:0] pop_data
);
  import tnig_pkg::*;

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/tnig_back.sv =====
`default_nettype none

module tnig_back #(
  parameter int WW = 9
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [WW-1:0]          width,
  input  wire  [1:0]             rad,
  input  wire                    head_valid,
  input  wire  [WW-1:0]          head_row,
  input  wire  [WW-1:0]          head_col,
  output logic                   head_pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tnig_pkg::idx_t         out_index,
  output tnig_pkg::slot_t        out_slot,
  output logic                   out_last
);
  import tnig_pkg::*;

  localparam int VW = WW + 3;
  localparam int PW = 2 * WW + 1;

  // (base + off) wrapped into 0..w-1 for off in -3..3. The sum stays
  // below 8w, so three conditional subtracts finish the reduction.
  function automatic logic [WW-1:0] wrap_add(input logic [WW-1:0] base,
                                             input logic signed [3:0] off,
                                             input logic [WW-1:0] w);
    logic [VW-1:0] v;
    logic [VW-1:0] wx;
    begin
      wx = VW'(w);
      v  = VW'(base) + (wx << 2) + VW'(off);
      if (v >= (wx << 2)) v = v - (wx << 2);
      if (v >= (wx << 1)) v = v - (wx << 1);
      if (v >= wx) v = v - wx;
      return WW'(v);
    end
  endfunction

  logic [2:0]       i_r;
  logic [2:0]       j_r;
  slot_t            slot_r;
  logic [2:0]       i_nxt;
  logic [2:0]       j_nxt;
  logic [2:0]       span;
  slot_t            last_slot;
  logic             is_last;
  logic             en;
  logic signed [3:0] dr;
  logic signed [3:0] dc;

  logic             s1_valid_r;
  logic [WW-1:0]    s1_r_r;
  logic [WW-1:0]    s1_c_r;
  slot_t            s1_slot_r;
  logic             s1_last_r;

  logic             out_valid_r;
  idx_t             out_index_r;
  slot_t            out_slot_r;
  logic             out_last_r;
  logic [PW-1:0]    lin;

  assign span      = {rad, 1'b0};
  assign last_slot = (rad == RAD_LARGE) ? LAST_SLOT_LARGE : LAST_SLOT_SMALL;
  assign is_last   = (slot_r == last_slot);
  assign en        = !out_valid_r || out_ready;
  assign head_pop  = en && head_valid && is_last;
  assign dr        = $signed({2'b00, rad}) - $signed({1'b0, i_r});
  assign dc        = $signed({1'b0, j_r}) - $signed({2'b00, rad});

  // Step through the block row by row, jumping over the centre cell.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r + 3'd1;
    if (j_r == span) begin
      i_nxt = i_r + 3'd1;
      j_nxt = 3'd0;
    end else if ((i_r == {1'b0, rad}) && (j_nxt == {1'b0, rad})) begin
      j_nxt = j_r + 3'd2;
    end
  end

  assign lin = PW'(s1_r_r * width) + PW'(s1_c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= 3'd0;
      j_r         <= 3'd0;
      slot_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= head_valid;
      out_valid_r <= s1_valid_r;
      if (head_valid) begin
        if (is_last) begin
          i_r    <= 3'd0;
          j_r    <= 3'd0;
          slot_r <= '0;
        end else begin
          i_r    <= i_nxt;
          j_r    <= j_nxt;
          slot_r <= slot_r + slot_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r_r      <= wrap_add(head_row, dr, width);
      s1_c_r      <= wrap_add(head_col, dc, width);
      s1_slot_r   <= slot_r;
      s1_last_r   <= is_last;
      out_index_r <= IDX_W'(lin);
      out_slot_r  <= s1_slot_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_slot_r == last_slot)))
    else $error("last flag does not match final slot");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_r_r < width) && (s1_c_r < width))
    else $error("wrapped coordinate outside the grid");

  a_no_centre: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> !((i_r == {1'b0, rad}) && (j_r == {1'b0, rad})))
    else $error("centre cell reached the output");

  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= span) && (j_r <= span))
    else $error("block position counter out of range");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import tnig_pkg::*;

  localparam int MAX_W       = 256;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    idx_t  neighbour;
    slot_t slot;
    logic  last;
  } neighbour_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  idx_t                 in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [GRID_W-1:0]    cfg_wdata  = '0;

  // Local copy of the block's registers, as seen after reset and every write.
  logic [GRID_W-1:0] grid_width_q = GRID_WIDTH_RESET;
  logic [RAD_W-1:0]  radius_q     = RAD_LARGE;

  neighbour_t expected_neighbours[$];
  int         mismatch_count = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  logic       hold_ready     = 1'b0;

  toroidal_neighbour_index_generator_top #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int effective_width(input logic [GRID_W-1:0] value);
    int w;
    w = int'(value);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  // Queue up the whole neighbourhood of one centre cell in emission order.
  task automatic predict_neighbours(input idx_t centre);
    int w, rad, row, col, r, c, n, total;
    neighbour_t item;
    w     = effective_width(grid_width_q);
    rad   = (radius_q == RAD_LARGE) ? 3 : 2;
    total = (2 * rad + 1) * (2 * rad + 1) - 1;
    col   = int'(centre) % w;
    row   = (int'(centre) / w) % w;
    n     = 0;
    for (int dr = rad; dr >= -rad; dr--) begin
      r = (row + 4 * w + dr) % w;
      for (int dc = -rad; dc <= rad; dc++) begin
        if (dr != 0 || dc != 0) begin
          c              = (col + 4 * w + dc) % w;
          item.neighbour = idx_t'(r * w + c);
          item.slot      = slot_t'(n);
          item.last      = (n == total - 1);
          expected_neighbours.push_back(item);
          n++;
        end
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [GRID_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_GRID_WIDTH) begin
      grid_width_q = value;
    end else begin
      radius_q = value[RAD_W-1:0];
    end
  endtask

  // Offers one word and returns at the edge where it is taken; valid stays
  // high so that a following call can present the next word without a gap.
  task automatic send_cell(input idx_t centre);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= centre;
    do @(posedge clk); while (!in_tready);
    predict_neighbours(centre);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_neighbours.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= !hold_ready && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    neighbour_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_neighbours.size() == 0) begin
        $error("unexpected word: neighbour_index %0d slot %0d last %0b",
               out_tdata[15:0], out_tdata[21:16], out_tlast);
        mismatch_count++;
      end else begin
        want = expected_neighbours.pop_front();
        if (out_tdata[15:0] !== want.neighbour) begin
          $error("neighbour_index: expected %0d, got %0d", want.neighbour, out_tdata[15:0]);
          mismatch_count++;
        end
        if (out_tdata[21:16] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[21:16]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: errors");
    $finish;
  end

  // Full-size grid and the large neighbourhood straight out of reset.
  task automatic test_reset_defaults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cell(idx_t'(0));
    send_cell(idx_t'(16'hFFFF));
    send_cell(idx_t'(255));
    send_cell(idx_t'(256));
    send_cell(idx_t'(16'hFF00));
    send_cell(idx_t'(257));
    send_cell(idx_t'(16'h5555));
    send_cell(idx_t'(16'hAAAA));
    wait_drained();
  endtask

  // Widths smaller than the neighbourhood, out-of-range register codes and
  // indexes that lie beyond the grid.
  task automatic test_odd_settings();
    write_reg(CFG_GRID_WIDTH, 9'd1);
    write_reg(CFG_RADIUS, GRID_W'(RAD_SMALL));
    send_cell(idx_t'(0));
    send_cell(idx_t'(16'hFFFF));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd0);
    write_reg(CFG_RADIUS, 9'd0);
    send_cell(idx_t'(1234));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd2);
    write_reg(CFG_RADIUS, GRID_W'(RAD_LARGE));
    send_cell(idx_t'(3));
    send_cell(idx_t'(5));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd3);
    write_reg(CFG_RADIUS, 9'd1);
    send_cell(idx_t'(8));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd7);
    write_reg(CFG_RADIUS, GRID_W'(RAD_LARGE));
    send_cell(idx_t'(48));
    send_cell(idx_t'(49));
    send_cell(idx_t'(700));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd511);
    send_cell(idx_t'(16'hFFFF));
    send_cell(idx_t'(0));
    wait_drained();
    write_reg(CFG_GRID_WIDTH, 9'd257);
    write_reg(CFG_RADIUS, GRID_W'(RAD_SMALL));
    send_cell(idx_t'(300));
    send_cell(idx_t'(16'hFFFF));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
    int w, pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 12 == 0) begin
        wait_drained();
        // Small grids wrap hardest, so they get most of the settings.
        pick = $urandom_range(99);
        if (pick < 60) begin
          write_reg(CFG_GRID_WIDTH, GRID_W'($urandom_range(1, 16)));
        end else if (pick < 90) begin
          write_reg(CFG_GRID_WIDTH, GRID_W'($urandom_range(17, 256)));
        end else begin
          write_reg(CFG_GRID_WIDTH, GRID_W'($urandom_range(0, 511)));
        end
        write_reg(CFG_RADIUS, GRID_W'($urandom_range(0, 3)));
      end
      w = effective_width(grid_width_q);
      if ($urandom_range(99) < 80) begin
        send_cell(idx_t'($urandom_range(0, w * w - 1)));
      end else begin
        send_cell(idx_t'($urandom_range(0, 65535)));
      end
    end
    wait_drained();
  endtask

  // The receiver holds off while words keep coming, so the block must
  // fill its queue and drop in_tready.
  task automatic test_backpressure();
    write_reg(CFG_GRID_WIDTH, GRID_WIDTH_RESET);
    write_reg(CFG_RADIUS, GRID_W'(RAD_LARGE));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_ready = 1'b1;
        repeat (300) @(posedge clk);
        hold_ready = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_cell(idx_t'($urandom_range(0, 65535)));
    join
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_odd_settings();
    test_random_traffic(0, 0, 40);
    test_random_traffic(82, 0, 35);
    test_random_traffic(0, 82, 35);
    test_random_traffic(8, 8, 35);
    test_backpressure();
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
